// ----- src/eqh_pkg.sv -----
package eqh_pkg;

    localparam int MAX_BINS  = 256;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int NB_W      = 9;
    localparam int DATA_W    = 32;
    localparam int QS_W      = 9;
    localparam int PW_W      = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOWEST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BINS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PLOT   = CFG_IDX_W'(3);

    localparam logic [NB_W-1:0] BINS_RESET = NB_W'(256);
    localparam logic [PW_W-1:0] PLOT_RESET = PW_W'(50);

    typedef enum logic [1:0] {
        DIV_IDX   = 2'd0,
        DIV_SCALE = 2'd1,
        DIV_BAR   = 2'd2
    } div_op_t;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        div_op_t div_op;
        logic    idx_load;
        logic    mem_rd;
        logic    update;
        logic    scale_load;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/equal_width_histogram.sv -----
// An add transaction runs a bin index divide of at most 9 steps on the shared radix-2 divider,
// then one registered read-modify-write of the count memory, a 32-step scale divide and a
// bar divide of at most 9 steps. A read skips the index divide and only reads the memory.
// The next transaction is accepted the cycle after the result is registered.
// Reset is asynchronous and active low; it clears the controller, the count valid bits
// and the largest count, and loads the register defaults. No clearing pass is needed.
module equal_width_histogram (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [31:0]                    sample,
    input  logic [7:0]                     read_bin,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     bin_index,
    output logic [31:0]                    bin_total,
    output logic [31:0]                    bin_low,
    output logic [31:0]                    bin_high,
    output logic [8:0]                     bar_length,
    output logic                           clamped,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [eqh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eqh_pkg::DATA_W-1:0]     cfg_data
);
    import eqh_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    eqh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    eqh_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .sample     (sample),
        .read_bin   (read_bin),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_index  (bin_index),
        .bin_total  (bin_total),
        .bin_low    (bin_low),
        .bin_high   (bin_high),
        .bar_length (bar_length),
        .clamped    (clamped)
    );

`ifndef SYNTHESIS
    // One transaction at a time: the engine is busy right after accepting one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in progress");

    // A pending result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken result");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

// ----- src/eqh_div.sv -----
module eqh_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        short_mode,
    input  logic [eqh_pkg::DATA_W-1:0]  dividend,
    input  logic [eqh_pkg::DATA_W:0]    divisor,
    output logic                        done,
    output logic [eqh_pkg::DATA_W-1:0]  quotient,
    output logic                        overflow
);
    import eqh_pkg::*;

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [DATA_W:0]     rem_reg;
    logic [DATA_W:0]     rem_next;
    logic [DATA_W-1:0]   sh_reg;
    logic [DATA_W-1:0]   sh_next;
    logic [DATA_W-1:0]   q_reg;
    logic [DATA_W-1:0]   q_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [DATA_W+1:0]   trial;
    logic [DATA_W+1:0]   diff;
    logic                ge;
    logic                short_ovf;

    assign trial     = {rem_reg, sh_reg[DATA_W-1]};
    assign diff      = trial - {1'b0, divisor};
    assign ge        = trial >= {1'b0, divisor};
    assign short_ovf = {1'b0, dividend >> QS_W} >= divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            q_next = '0;
            if (short_mode)
            begin
                // Short quotient: the upper quotient bits are known to be zero.
                ovf_next  = short_ovf;
                rem_next  = {1'b0, dividend >> QS_W};
                sh_next   = dividend << (DATA_W - QS_W);
                step_next = STEP_W'(QS_W);
                busy_next = !short_ovf;
                done_next = short_ovf;
            end
            else
            begin
                ovf_next  = 1'b0;
                rem_next  = '0;
                sh_next   = dividend;
                step_next = STEP_W'(DATA_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DATA_W:0] : trial[DATA_W:0];
            q_next    = {q_reg[DATA_W-2:0], ge};
            sh_next   = sh_reg << 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

// ----- src/eqh_datapath.sv -----
module eqh_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  eqh_pkg::ctrl_cmd_t             cmd,
    output eqh_pkg::dp_status_t            status,
    input  logic                           cfg_write,
    input  logic [eqh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eqh_pkg::DATA_W-1:0]     cfg_data,
    input  logic                           mode,
    input  logic [31:0]                    sample,
    input  logic [7:0]                     read_bin,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     bin_index,
    output logic [31:0]                    bin_total,
    output logic [31:0]                    bin_low,
    output logic [31:0]                    bin_high,
    output logic [8:0]                     bar_length,
    output logic                           clamped
);
    import eqh_pkg::*;

    logic [DATA_W-1:0]  lowest_reg;
    logic [DATA_W-1:0]  span_reg;
    logic [NB_W-1:0]    bins_reg;
    logic [PW_W-1:0]    plot_reg;

    logic [DATA_W-1:0]  cnt_mem [MAX_BINS];
    logic [MAX_BINS-1:0] vbit_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;
    logic [DATA_W-1:0]  largest_reg;

    logic               mode_reg;
    logic [DATA_W-1:0]  sample_reg;
    logic [BIN_W-1:0]   idx_reg;
    logic               clamp_reg;
    logic [DATA_W-1:0]  count_reg;
    logic [DATA_W-1:0]  prod_reg;
    logic [DATA_W-1:0]  low_reg;
    logic [DATA_W-1:0]  scale_reg;
    logic               out_valid_reg;

    logic [NB_W-1:0]    nb;
    logic [PW_W-1:0]    plot_eff;
    logic [BIN_W-1:0]   read_idx;
    logic               below;
    logic               over;
    logic [BIN_W-1:0]   hit_idx;
    logic [DATA_W-1:0]  cur_count;
    logic [DATA_W-1:0]  new_count;
    logic               mem_we;

    logic               div_short;
    logic [DATA_W-1:0]  div_dividend;
    logic [DATA_W:0]    div_divisor;
    logic               div_done;
    logic [DATA_W-1:0]  div_q;
    logic               div_ovf;

    always_comb
    begin
        if (bins_reg == '0)
        begin
            nb = NB_W'(1);
        end
        else if (32'(bins_reg) > 32'(MAX_BINS))
        begin
            nb = NB_W'(MAX_BINS);
        end
        else
        begin
            nb = bins_reg;
        end
    end

    assign plot_eff = (plot_reg == '0) ? PW_W'(1) : plot_reg;
    assign read_idx = (32'(read_bin) >= 32'(MAX_BINS)) ? BIN_W'(MAX_BINS - 1)
                                                        : BIN_W'(read_bin);

    assign below   = sample_reg < lowest_reg;
    assign over    = div_ovf || (div_q[QS_W-1:0] >= nb);
    assign hit_idx = below ? '0 : (over ? BIN_W'(nb - NB_W'(1)) : div_q[BIN_W-1:0]);

    assign cur_count = rd_valid_reg ? rd_data_reg : '0;
    assign new_count = (cur_count == '1) ? cur_count : cur_count + DATA_W'(1);
    assign mem_we    = cmd.update && !mode_reg;

    always_comb
    begin
        case (cmd.div_op)
            DIV_IDX:
            begin
                div_short    = 1'b1;
                div_dividend = sample_reg - lowest_reg;
                div_divisor  = {1'b0, span_reg} + (DATA_W+1)'(1);
            end
            DIV_SCALE:
            begin
                div_short    = 1'b0;
                div_dividend = largest_reg;
                div_divisor  = (DATA_W+1)'(plot_eff);
            end
            DIV_BAR:
            begin
                div_short    = 1'b1;
                div_dividend = count_reg;
                div_divisor  = {1'b0, scale_reg};
            end
            default:
            begin
                div_short    = 1'b1;
                div_dividend = count_reg;
                div_divisor  = {1'b0, scale_reg};
            end
        endcase
    end

    eqh_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .short_mode (div_short),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .done       (div_done),
        .quotient   (div_q),
        .overflow   (div_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg <= '0;
            span_reg   <= '0;
            bins_reg   <= BINS_RESET;
            plot_reg   <= PLOT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOWEST: lowest_reg <= cfg_data;
                REG_SPAN:   span_reg   <= cfg_data;
                REG_BINS:   bins_reg   <= cfg_data[NB_W-1:0];
                REG_PLOT:   plot_reg   <= cfg_data[PW_W-1:0];
                default:    lowest_reg <= lowest_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[idx_reg] <= new_count;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg  <= cnt_mem[idx_reg];
            rd_valid_reg <= vbit_reg[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg      <= '0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vbit_reg[idx_reg] <= 1'b1;
                if (new_count > largest_reg)
                begin
                    largest_reg <= new_count;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= mode;
            sample_reg <= sample;
            idx_reg    <= read_idx;
            clamp_reg  <= 1'b0;
        end
        if (cmd.idx_load)
        begin
            idx_reg   <= hit_idx;
            clamp_reg <= below || over;
        end
        if (cmd.mem_rd)
        begin
            prod_reg <= DATA_W'(idx_reg) * span_reg;
        end
        if (cmd.update)
        begin
            count_reg <= mode_reg ? cur_count : new_count;
            low_reg   <= lowest_reg + prod_reg + DATA_W'(idx_reg);
        end
        if (cmd.scale_load)
        begin
            scale_reg <= (div_q == '0) ? DATA_W'(1) : div_q;
        end
        if (cmd.out_load)
        begin
            bin_index  <= 8'(idx_reg);
            bin_total  <= count_reg;
            bin_low    <= low_reg;
            bin_high   <= low_reg + span_reg;
            bar_length <= div_ovf ? '1 : div_q[8:0];
            clamped    <= clamp_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// ----- src/eqh_ctrl.sv -----
module eqh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 mode,
    output logic                 in_ready,
    input  eqh_pkg::dp_status_t  status,
    output eqh_pkg::ctrl_cmd_t   cmd
);
    import eqh_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE        = 10'b0000000001,
        ST_IDX_START   = 10'b0000000010,
        ST_IDX_WAIT    = 10'b0000000100,
        ST_READ        = 10'b0000001000,
        ST_UPDATE      = 10'b0000010000,
        ST_SCALE_START = 10'b0000100000,
        ST_SCALE_WAIT  = 10'b0001000000,
        ST_BAR_START   = 10'b0010000000,
        ST_BAR_WAIT    = 10'b0100000000,
        ST_FINISH      = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = mode ? ST_READ : ST_IDX_START;
                end
            end
            ST_IDX_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_IDX;
                state_next    = ST_IDX_WAIT;
            end
            ST_IDX_WAIT:
            begin
                cmd.div_op = DIV_IDX;
                if (status.div_done)
                begin
                    cmd.idx_load = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_SCALE_START;
            end
            ST_SCALE_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SCALE;
                state_next    = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT:
            begin
                cmd.div_op = DIV_SCALE;
                if (status.div_done)
                begin
                    cmd.scale_load = 1'b1;
                    state_next     = ST_BAR_START;
                end
            end
            ST_BAR_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_BAR;
                state_next    = ST_BAR_WAIT;
            end
            ST_BAR_WAIT:
            begin
                cmd.div_op = DIV_BAR;
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.div_op = DIV_BAR;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule
